>>> rtl/cbpa_pkg.sv
// Shared constants and types of the chunked block pool allocator.
package cbpa_pkg;

  localparam int unsigned CHUNK_BYTES = 1024 * 1024;
  localparam int unsigned NUM_CHUNKS  = 8;
  localparam int unsigned MAX_BLOCKS  = 4096;

  localparam int unsigned ADDR_W   = 23;
  localparam int unsigned OFF_W    = $clog2(CHUNK_BYTES);
  localparam int unsigned SLOT_W   = $clog2(NUM_CHUNKS);
  localparam int unsigned IDX_W    = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W    = IDX_W + 1;
  localparam int unsigned LEN_W    = SLOT_W + 1;
  localparam int unsigned BSIZE_W  = 21;
  localparam int unsigned REL_W    = 4;
  localparam int unsigned MEM_AW   = SLOT_W + IDX_W;
  localparam int unsigned MEM_DEPTH = NUM_CHUNKS * MAX_BLOCKS;
  localparam int unsigned QUO_W    = BSIZE_W;
  localparam int unsigned DIVC_W   = $clog2(QUO_W);

  localparam logic [BSIZE_W-1:0] BSIZE_RESET = BSIZE_W'(256);
  localparam logic [CNT_W-1:0]   CAP_MAX     = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0]   CAP_RESET   = CNT_W'(CHUNK_BYTES / 256);

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_SHRINK = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_CHUNK = 2'd1,
    ST_INACTIVE = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

endpackage

>>> rtl/chunked_block_pool_allocator.sv
// Chunked block pool allocator: per-chunk free stacks in one RAM, list and counts in registers.
//
//  Channel   Direction  Handshake                  Payload
//  in        input      in_valid_i / in_stall_o    operation_i, address_i
//  out       output     out_valid_o / out_stall_i  block_address_o, status_o, released_o
//  cfg       input      cfg_wr_en_i                cfg_wr_data_i (block size)
//
// A free, or an unknown op, goes straight to S_OUT, which loads the output register; an allocate
// from a listed chunk passes S_ALLOC and S_ARD (stack RAM read) before S_OUT.
// Activating a chunk first fills its stack RAM in S_FILL, one entry per block of capacity.
// Shrink visits each listed chunk in S_SHRINK; a block size write runs the bit-serial capacity
// division in S_DIV. The stack RAM has no clearing pass after reset. The input stalls while a
// request is in progress; a finished result waits in the output register while the next request is taken.
module chunked_block_pool_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    operation_i,
  input  logic [cbpa_pkg::ADDR_W-1:0]   address_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cbpa_pkg::ADDR_W-1:0]   block_address_o,
  output logic [1:0]                    status_o,
  output logic [cbpa_pkg::REL_W-1:0]    released_o,
  input  logic                          cfg_wr_en_i,
  input  logic [cbpa_pkg::BSIZE_W-1:0]  cfg_wr_data_i
);
  import cbpa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_FILL, S_ALLOC, S_ARD, S_SHRINK, S_OUT, S_DIV
  } state_e;

  state_e state_q;

  logic [BSIZE_W-1:0] bsize_q;
  logic [CNT_W-1:0]   cap_q;
  logic [CNT_W-1:0]   fcount_q [NUM_CHUNKS];
  logic [NUM_CHUNKS-1:0] active_q;
  logic [SLOT_W-1:0]  order_q [NUM_CHUNKS];
  logic [LEN_W-1:0]   len_q;

  logic [SLOT_W-1:0]  slot_q;
  logic [IDX_W-1:0]   fill_idx_q;
  logic [OFF_W-1:0]   fill_val_q;
  logic [LEN_W-1:0]   rd_q;
  logic [LEN_W-1:0]   wr_q;
  logic [LEN_W-1:0]   snap_len_q;
  logic [REL_W-1:0]   rel_q;

  logic [BSIZE_W-1:0] div_rem_q;
  logic [QUO_W-1:0]   div_quo_q;
  logic [DIVC_W-1:0]  div_cnt_q;

  logic [ADDR_W-1:0]  res_addr_q;
  status_e            res_status_q;
  logic [REL_W-1:0]   res_rel_q;

  logic               out_valid_q;
  logic [ADDR_W-1:0]  out_addr_q;
  status_e            out_status_q;
  logic [REL_W-1:0]   out_rel_q;

  // Stack RAM ports.
  logic               mem_we;
  logic [MEM_AW-1:0]  mem_waddr;
  logic [OFF_W-1:0]   mem_wdata;
  logic               mem_re;
  logic [MEM_AW-1:0]  mem_raddr;
  logic [OFF_W-1:0]   mem_rdata_q;
  logic [OFF_W-1:0]   stack_mem [MEM_DEPTH];

  logic               accept;
  op_e                op;
  logic [SLOT_W-1:0]  in_slot;
  logic [CNT_W-1:0]   in_cnt;
  logic [SLOT_W-1:0]  head_slot;
  logic [CNT_W-1:0]   head_cnt;
  logic [SLOT_W-1:0]  shr_slot;
  logic [SLOT_W-1:0]  free_slot;
  logic               free_found;
  logic [BSIZE_W:0]   div_shift;
  logic               div_ge;
  logic [QUO_W-1:0]   div_quo_next;
  logic               out_free;

  assign op         = op_e'(operation_i);
  assign in_stall_o = (state_q != S_IDLE) || cfg_wr_en_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_slot    = address_i[ADDR_W-1 -: SLOT_W];
  assign in_cnt     = fcount_q[in_slot];
  assign head_slot  = order_q[0];
  assign head_cnt   = fcount_q[head_slot];
  assign shr_slot   = order_q[rd_q[SLOT_W-1:0]];
  assign out_free   = !out_valid_q || !out_stall_i;

  // Lowest inactive slot.
  always_comb begin
    free_slot  = '0;
    free_found = 1'b0;
    for (int i = NUM_CHUNKS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_slot  = SLOT_W'(i);
        free_found = 1'b1;
      end
    end
  end

  // One restoring step of CHUNK_BYTES / block size, dividend bit taken by position.
  assign div_shift    = {div_rem_q, (32'(div_cnt_q) == OFF_W)};
  assign div_ge       = div_shift >= {1'b0, bsize_q};
  assign div_quo_next = {div_quo_q[QUO_W-2:0], div_ge};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {slot_q, fill_idx_q};
    mem_wdata = fill_val_q;
    mem_re    = 1'b0;
    mem_raddr = {head_slot, IDX_W'(head_cnt - CNT_W'(1))};
    if (state_q == S_FILL) begin
      mem_we = 1'b1;
    end else if (accept && op == OP_FREE && active_q[in_slot] && in_cnt < cap_q) begin
      mem_we    = 1'b1;
      mem_waddr = {in_slot, in_cnt[IDX_W-1:0]};
      mem_wdata = address_i[OFF_W-1:0];
    end
    if (state_q == S_ALLOC && head_cnt != '0 && head_cnt <= CAP_MAX) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= stack_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      bsize_q      <= BSIZE_RESET;
      cap_q        <= CAP_RESET;
      active_q     <= '0;
      len_q        <= '0;
      for (int i = 0; i < NUM_CHUNKS; i++) begin
        fcount_q[i] <= '0;
      end
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cfg_wr_en_i && active_q == '0) begin
            bsize_q   <= cfg_wr_data_i;
            div_rem_q <= '0;
            div_quo_q <= '0;
            div_cnt_q <= DIVC_W'(OFF_W);
            state_q   <= S_DIV;
          end else if (accept) begin
            res_addr_q <= '0;
            res_rel_q  <= '0;
            unique case (op)
              OP_ALLOC: begin
                if (len_q != '0) begin
                  res_status_q <= ST_OK;
                  state_q      <= S_ALLOC;
                end else if (cap_q == '0 || !free_found) begin
                  res_status_q <= ST_NO_CHUNK;
                  state_q      <= S_OUT;
                end else begin
                  res_status_q        <= ST_OK;
                  active_q[free_slot] <= 1'b1;
                  slot_q     <= free_slot;
                  fill_idx_q <= '0;
                  fill_val_q <= '0;
                  state_q    <= S_FILL;
                end
              end
              OP_FREE: begin
                state_q <= S_OUT;
                if (!active_q[in_slot]) begin
                  res_status_q <= ST_INACTIVE;
                end else if (in_cnt >= cap_q) begin
                  res_status_q <= ST_OVERFLOW;
                end else begin
                  res_status_q <= ST_OK;
                  // A full chunk goes back to the front of the list.
                  if (in_cnt == '0 && len_q < LEN_W'(NUM_CHUNKS)) begin
                    for (int i = 1; i < NUM_CHUNKS; i++) begin
                      order_q[i] <= order_q[i-1];
                    end
                    order_q[0] <= in_slot;
                    len_q      <= len_q + LEN_W'(1);
                  end
                  fcount_q[in_slot] <= in_cnt + CNT_W'(1);
                end
              end
              OP_SHRINK: begin
                res_status_q <= ST_OK;
                rd_q       <= '0;
                wr_q       <= '0;
                rel_q      <= '0;
                snap_len_q <= len_q;
                state_q    <= S_SHRINK;
              end
              default: begin
                res_status_q <= ST_OK;
                state_q      <= S_OUT;
              end
            endcase
          end
        end
        S_FILL: begin
          fill_idx_q <= fill_idx_q + IDX_W'(1);
          fill_val_q <= fill_val_q + OFF_W'(bsize_q);
          if ({1'b0, fill_idx_q} == cap_q - CNT_W'(1)) begin
            fcount_q[slot_q] <= cap_q;
            order_q[0]       <= slot_q;
            len_q            <= LEN_W'(1);
            state_q          <= S_ALLOC;
          end
        end
        S_ALLOC: begin
          if (head_cnt == '0 || head_cnt > CAP_MAX) begin
            res_status_q <= ST_NO_CHUNK;
            state_q      <= S_OUT;
          end else begin
            fcount_q[head_slot] <= head_cnt - CNT_W'(1);
            slot_q              <= head_slot;
            // The chunk is now full and leaves the list.
            if (head_cnt == CNT_W'(1)) begin
              for (int i = 0; i < NUM_CHUNKS - 1; i++) begin
                order_q[i] <= order_q[i+1];
              end
              len_q <= len_q - LEN_W'(1);
            end
            state_q <= S_ARD;
          end
        end
        S_ARD: begin
          res_addr_q <= {slot_q, {OFF_W{1'b0}}} + ADDR_W'(mem_rdata_q);
          state_q    <= S_OUT;
        end
        S_SHRINK: begin
          if (rd_q == snap_len_q) begin
            len_q     <= wr_q;
            res_rel_q <= rel_q;
            state_q   <= S_OUT;
          end else begin
            if (fcount_q[shr_slot] == cap_q && (snap_len_q - LEN_W'(rel_q)) > LEN_W'(1)) begin
              active_q[shr_slot] <= 1'b0;
              fcount_q[shr_slot] <= '0;
              rel_q              <= rel_q + REL_W'(1);
            end else begin
              order_q[wr_q[SLOT_W-1:0]] <= shr_slot;
              wr_q                      <= wr_q + LEN_W'(1);
            end
            rd_q <= rd_q + LEN_W'(1);
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_addr_q   <= res_addr_q;
            out_status_q <= res_status_q;
            out_rel_q    <= res_rel_q;
            state_q      <= S_IDLE;
          end
        end
        S_DIV: begin
          div_rem_q <= div_ge ? BSIZE_W'(div_shift - {1'b0, bsize_q}) : div_shift[BSIZE_W-1:0];
          div_quo_q <= div_quo_next;
          div_cnt_q <= div_cnt_q - DIVC_W'(1);
          if (div_cnt_q == '0) begin
            cap_q   <= (div_quo_next > QUO_W'(MAX_BLOCKS)) ? CAP_MAX : div_quo_next[CNT_W-1:0];
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign block_address_o = out_addr_q;
  assign status_o        = out_status_q;
  assign released_o      = out_rel_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(NUM_CHUNKS))
    else $error("chunk list longer than the slot count");

  // Shrink clears active bits before the list length is written back.
  a_listed_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_SHRINK) |-> (LEN_W'($countones(active_q)) >= len_q))
    else $error("more listed chunks than active chunks");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != '0 && state_q == S_IDLE) |-> (head_cnt <= cap_q && head_cnt != '0))
    else $error("listed head chunk has a bad free count");

  a_fill_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> active_q[slot_q])
    else $error("filling a chunk that is not active");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !out_free) |=> (state_q == S_OUT))
    else $error("result dropped while output stalled");

endmodule
